>>> hdl/pfb_pkg.sv
// Shared types and constants for the pixel format to BGR24 converter.
package pfb_pkg;

   // Register indexes on the configuration port
   localparam logic [2:0] REG_BYTES_PER_PIXEL = 3'd0;
   localparam logic [2:0] REG_PALETTED_MODE   = 3'd1;
   localparam logic [2:0] REG_RED_MASK        = 3'd2;
   localparam logic [2:0] REG_GREEN_MASK      = 3'd3;
   localparam logic [2:0] REG_BLUE_MASK       = 3'd4;

   // Input item opcodes
   localparam logic OP_CONVERT   = 1'b0;
   localparam logic OP_PAL_WRITE = 1'b1;

   // Channel lanes in the datapath
   localparam int CH_BLUE  = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_RED   = 2;
   localparam int NUM_CH   = 3;

   // Quotient bits produced by the divider
   localparam int DIV_STEPS = 8;

   typedef struct packed {
      logic [2:0]  bytes_per_pixel;
      logic        paletted_mode;
      logic [31:0] red_mask;
      logic [31:0] green_mask;
      logic [31:0] blue_mask;
   } pfb_cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAL_WAIT,
      ST_SCAN,
      ST_DIVIDE,
      ST_EMIT
   } pfb_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic pal_write;
      logic pal_read;
      logic scan_step;
      logic div_prep;
      logic div_step;
      logic out_load;
   } pfb_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic scan_done;
      logic out_free;
   } pfb_sts_type;

endpackage

>>> hdl/pfb_csr.sv
// Configuration register file with APB-style access.
module pfb_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   output pfb_pkg::pfb_cfg_type cfg
);

   pfb_pkg::pfb_cfg_type cfg_ff;
   pfb_pkg::pfb_cfg_type cfg_in;
   logic [2:0]           reg_idx;
   logic                 wr_en;

   assign reg_idx = paddr[4:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   // Decode writes
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            pfb_pkg::REG_BYTES_PER_PIXEL: cfg_in.bytes_per_pixel = pwdata[2:0];
            pfb_pkg::REG_PALETTED_MODE:   cfg_in.paletted_mode   = pwdata[0];
            pfb_pkg::REG_RED_MASK:        cfg_in.red_mask        = pwdata;
            pfb_pkg::REG_GREEN_MASK:      cfg_in.green_mask      = pwdata;
            pfb_pkg::REG_BLUE_MASK:       cfg_in.blue_mask       = pwdata;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Return register contents
   always_comb begin
      unique case (reg_idx)
         pfb_pkg::REG_BYTES_PER_PIXEL: prdata = {29'd0, cfg_ff.bytes_per_pixel};
         pfb_pkg::REG_PALETTED_MODE:   prdata = {31'd0, cfg_ff.paletted_mode};
         pfb_pkg::REG_RED_MASK:        prdata = cfg_ff.red_mask;
         pfb_pkg::REG_GREEN_MASK:      prdata = cfg_ff.green_mask;
         pfb_pkg::REG_BLUE_MASK:       prdata = cfg_ff.blue_mask;
         default:                      prdata = '0;
      endcase
   end

endmodule

>>> hdl/pfb_datapath.sv
// Datapath: pixel capture, mask scan, per-channel dividers, palette memory, output beat.
module pfb_datapath #(
   parameter int PALETTE_ENTRIES = 256,
   parameter int MAX_PIXEL_BYTES = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pfb_pkg::pfb_cmd_type cmd,
   output pfb_pkg::pfb_sts_type sts,
   input  pfb_pkg::pfb_cfg_type cfg,
   input  logic [31:0]          req_pixel_word,
   input  logic                 req_end_of_line,
   input  logic [7:0]           req_palette_index,
   input  logic [7:0]           req_palette_red,
   input  logic [7:0]           req_palette_green,
   input  logic [7:0]           req_palette_blue,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_blue_out,
   output logic [7:0]           rsp_green_out,
   output logic [7:0]           rsp_red_out,
   output logic                 rsp_line_last
);

   localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

   // Per-channel scan and divide lanes
   logic [31:0] mask_ff [pfb_pkg::NUM_CH];
   logic [31:0] mask_in [pfb_pkg::NUM_CH];
   logic [31:0] pix_ff  [pfb_pkg::NUM_CH];
   logic [31:0] pix_in  [pfb_pkg::NUM_CH];
   logic [7:0]  dvs_ff  [pfb_pkg::NUM_CH];
   logic [7:0]  dvs_in  [pfb_pkg::NUM_CH];
   logic [7:0]  rem_ff  [pfb_pkg::NUM_CH];
   logic [7:0]  rem_in  [pfb_pkg::NUM_CH];
   logic [7:0]  quo_ff  [pfb_pkg::NUM_CH];
   logic [7:0]  quo_in  [pfb_pkg::NUM_CH];
   logic [pfb_pkg::NUM_CH-1:0] ch_done;

   logic        eol_ff;
   logic        pal_mode_ff;
   logic [2:0]  bpp_eff;
   logic [31:0] pix_masked;

   // Palette storage
   logic [23:0] pal_mem [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] pal_vld_ff;
   logic [23:0] pal_rd_ff;
   logic        pal_hit_ff;
   logic        wr_in_range;
   logic        rd_in_range;
   logic [PAL_AW-1:0] wr_addr;
   logic [PAL_AW-1:0] rd_addr;

   // Output beat
   logic        rsp_valid_ff;
   logic [7:0]  blue_ff;
   logic [7:0]  green_ff;
   logic [7:0]  red_ff;
   logic        last_ff;

   // Clamp the pixel size and drop bytes above it
   always_comb begin
      bpp_eff = (cfg.bytes_per_pixel > 3'(MAX_PIXEL_BYTES)) ? 3'(MAX_PIXEL_BYTES)
                                                            : cfg.bytes_per_pixel;
      for (int k = 0; k < 4; k++) begin
         pix_masked[k*8 +: 8] = (3'(k) < bpp_eff) ? req_pixel_word[k*8 +: 8] : 8'd0;
      end
   end

   // Lane next values: load, skip trailing zeros, set up and run the divider
   always_comb begin
      logic [31:0] src_mask [pfb_pkg::NUM_CH];
      logic [8:0]  trial;
      logic        ge;
      logic [7:0]  m;
      logic [7:0]  f;
      logic [15:0] num;
      src_mask[pfb_pkg::CH_BLUE]  = cfg.blue_mask;
      src_mask[pfb_pkg::CH_GREEN] = cfg.green_mask;
      src_mask[pfb_pkg::CH_RED]   = cfg.red_mask;
      for (int c = 0; c < pfb_pkg::NUM_CH; c++) begin
         mask_in[c] = mask_ff[c];
         pix_in[c]  = pix_ff[c];
         dvs_in[c]  = dvs_ff[c];
         rem_in[c]  = rem_ff[c];
         quo_in[c]  = quo_ff[c];
         ch_done[c] = (mask_ff[c] == 32'd0) || mask_ff[c][0];
         m     = (|mask_ff[c][31:8]) ? 8'hff : mask_ff[c][7:0];
         f     = pix_ff[c][7:0] & m;
         num   = {f, 8'd0} - {8'd0, f};
         trial = {rem_ff[c], quo_ff[c][7]};
         ge    = (trial >= {1'b0, dvs_ff[c]});
         if (cmd.load) begin
            mask_in[c] = src_mask[c];
            pix_in[c]  = pix_masked;
         end else if (cmd.scan_step && !ch_done[c]) begin
            if (mask_ff[c][3:0] == 4'd0) begin
               mask_in[c] = {4'd0, mask_ff[c][31:4]};
               pix_in[c]  = {4'd0, pix_ff[c][31:4]};
            end else begin
               mask_in[c] = {1'd0, mask_ff[c][31:1]};
               pix_in[c]  = {1'd0, pix_ff[c][31:1]};
            end
         end else if (cmd.div_prep) begin
            // quotient fits 8 bits since field <= divisor, so start at the high byte
            dvs_in[c] = m;
            rem_in[c] = num[15:8];
            quo_in[c] = num[7:0];
         end else if (cmd.div_step) begin
            rem_in[c] = ge ? 8'(trial - {1'b0, dvs_ff[c]}) : trial[7:0];
            quo_in[c] = {quo_ff[c][6:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < pfb_pkg::NUM_CH; c++) begin
         mask_ff[c] <= mask_in[c];
         pix_ff[c]  <= pix_in[c];
         dvs_ff[c]  <= dvs_in[c];
         rem_ff[c]  <= rem_in[c];
         quo_ff[c]  <= quo_in[c];
      end
      if (cmd.load) begin
         eol_ff      <= req_end_of_line;
         pal_mode_ff <= cfg.paletted_mode;
      end
   end

   // Palette write and registered lookup
   assign wr_in_range = ({1'b0, req_palette_index} < 9'(PALETTE_ENTRIES));
   assign rd_in_range = ({1'b0, req_pixel_word[7:0]} < 9'(PALETTE_ENTRIES));
   assign wr_addr     = req_palette_index[PAL_AW-1:0];
   assign rd_addr     = req_pixel_word[PAL_AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.pal_write && wr_in_range) begin
         pal_mem[wr_addr] <= {req_palette_red, req_palette_green, req_palette_blue};
      end
      if (cmd.pal_read) begin
         pal_rd_ff <= pal_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pal_vld_ff <= '0;
         pal_hit_ff <= 1'b0;
      end else begin
         if (cmd.pal_write && wr_in_range) begin
            pal_vld_ff[wr_addr] <= 1'b1;
         end
         if (cmd.pal_read) begin
            pal_hit_ff <= rd_in_range && pal_vld_ff[rd_addr];
         end
      end
   end

   // Hold the result beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         last_ff <= eol_ff;
         if (pal_mode_ff) begin
            red_ff   <= pal_hit_ff ? pal_rd_ff[23:16] : 8'd0;
            green_ff <= pal_hit_ff ? pal_rd_ff[15:8]  : 8'd0;
            blue_ff  <= pal_hit_ff ? pal_rd_ff[7:0]   : 8'd0;
         end else begin
            // a zero divisor comes only from an empty mask
            blue_ff  <= (dvs_ff[pfb_pkg::CH_BLUE]  == 8'd0) ? 8'd0 : quo_ff[pfb_pkg::CH_BLUE];
            green_ff <= (dvs_ff[pfb_pkg::CH_GREEN] == 8'd0) ? 8'd0 : quo_ff[pfb_pkg::CH_GREEN];
            red_ff   <= (dvs_ff[pfb_pkg::CH_RED]   == 8'd0) ? 8'd0 : quo_ff[pfb_pkg::CH_RED];
         end
      end
   end

   assign sts.scan_done = &ch_done;
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_blue_out  = blue_ff;
   assign rsp_green_out = green_ff;
   assign rsp_red_out   = red_ff;
   assign rsp_line_last = last_ff;

endmodule

>>> hdl/pfb_ctrl.sv
// Controller state machine sequencing accept, scan, divide and output.
module pfb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_opcode,
   input  pfb_pkg::pfb_cfg_type cfg,
   input  pfb_pkg::pfb_sts_type sts,
   output pfb_pkg::pfb_cmd_type cmd
);

   pfb_pkg::pfb_state_type state_ff;
   pfb_pkg::pfb_state_type state_in;
   logic [2:0]             cnt_ff;
   logic [2:0]             cnt_in;
   logic                   accept;

   assign req_stall = (state_ff != pfb_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfb_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         pfb_pkg::ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               if (req_opcode == pfb_pkg::OP_PAL_WRITE) begin
                  cmd.pal_write = 1'b1;
               end else if (cfg.bytes_per_pixel != 3'd0) begin
                  if (cfg.paletted_mode) begin
                     cmd.pal_read = 1'b1;
                     state_in     = pfb_pkg::ST_PAL_WAIT;
                  end else begin
                     state_in = pfb_pkg::ST_SCAN;
                  end
               end
            end
         end
         pfb_pkg::ST_PAL_WAIT: begin
            state_in = pfb_pkg::ST_EMIT;
         end
         pfb_pkg::ST_SCAN: begin
            if (sts.scan_done) begin
               cmd.div_prep = 1'b1;
               cnt_in       = '0;
               state_in     = pfb_pkg::ST_DIVIDE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         pfb_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 3'd1;
            if (cnt_ff == 3'(pfb_pkg::DIV_STEPS - 1)) begin
               state_in = pfb_pkg::ST_EMIT;
            end
         end
         pfb_pkg::ST_EMIT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = pfb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pfb_pkg::ST_IDLE;
         end
      endcase
   end

   // Never overwrite a beat still waiting downstream
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("output loaded while previous beat is stalled");

   // Paletted convert goes to the lookup wait
   a_pal_path: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == pfb_pkg::OP_CONVERT && cfg.paletted_mode &&
       cfg.bytes_per_pixel != 3'd0) |=> state_ff == pfb_pkg::ST_PAL_WAIT)
      else $error("paletted convert did not start lookup");

   // Divider always starts from step zero
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == pfb_pkg::ST_DIVIDE) |-> cnt_ff == 3'd0)
      else $error("divide started with stale step count");

   // An emitted beat returns to idle
   a_emit_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfb_pkg::ST_EMIT && sts.out_free) |=> state_ff == pfb_pkg::ST_IDLE)
      else $error("controller did not return to idle after emit");

endmodule

>>> hdl/pixel_format_to_bgr24.sv
// Top level of the pixel format to BGR24 converter.
// Usage: configure bytes_per_pixel, paletted_mode and the three channel
// masks over the APB-style port while the block is idle, then send items on
// the req_ channel. An opcode of palette write stores one 24-bit palette
// entry and gives no beat; a convert item gives one beat on the rsp_ channel
// with blue, green and red bytes and the line-last flag, except when
// bytes_per_pixel is 0, which drops the item.
// Sequence: a palette write or a dropped convert ends at accept. A paletted
// convert runs accept, registered palette read, output load. An RGB convert
// runs accept, then the trailing-zero skip steps of the slowest mask (4 bits
// or 1 bit per step), then one divider setup step and the restoring divider
// that produces one quotient bit per cycle in each channel, then output load.
// The result beat sits in an output register; the next item is accepted
// while it waits. If rsp_stall holds, the next result waits in the
// datapath and req_stall stays high until the beat is taken.
// Reset clears the configuration and control registers, the output valid and every palette entry's
// valid bit, so unwritten entries read as zero; no clearing pass is needed.
module pixel_format_to_bgr24 #(
   parameter int PALETTE_ENTRIES = 256,
   parameter int MAX_PIXEL_BYTES = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [31:0] req_pixel_word,
   input  logic        req_end_of_line,
   input  logic [7:0]  req_palette_index,
   input  logic [7:0]  req_palette_red,
   input  logic [7:0]  req_palette_green,
   input  logic [7:0]  req_palette_blue,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_blue_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_red_out,
   output logic        rsp_line_last
);

   pfb_pkg::pfb_cfg_type cfg;
   pfb_pkg::pfb_cmd_type cmd;
   pfb_pkg::pfb_sts_type sts;

   pfb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pfb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .cfg        (cfg),
      .sts        (sts),
      .cmd        (cmd)
   );

   pfb_datapath #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES),
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .cfg               (cfg),
      .req_pixel_word    (req_pixel_word),
      .req_end_of_line   (req_end_of_line),
      .req_palette_index (req_palette_index),
      .req_palette_red   (req_palette_red),
      .req_palette_green (req_palette_green),
      .req_palette_blue  (req_palette_blue),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_blue_out      (rsp_blue_out),
      .rsp_green_out     (rsp_green_out),
      .rsp_red_out       (rsp_red_out),
      .rsp_line_last     (rsp_line_last)
   );

endmodule

>>> tb/tb.sv
// Self-checking testbench for the pixel format to BGR24 converter.
module tb;

   localparam int PAL_DEPTH   = 256;
   localparam int WIDEST_PIX  = 4;
   localparam int SETTLE_GAP  = 32;
   localparam int STUCK_LIMIT = 2000;
   localparam int RAND_PHASES = 12;
   localparam int PHASE_ITEMS = 62;

   typedef enum logic {ROW_CSR, ROW_ITEM} row_kind_type;

   typedef struct packed {
      logic        op;
      logic [31:0] pixel;
      logic        eol;
      logic [7:0]  pal_idx;
      logic [7:0]  pal_r;
      logic [7:0]  pal_g;
      logic [7:0]  pal_b;
   } pixel_item_type;

   typedef struct packed {
      logic [7:0] b;
      logic [7:0] g;
      logic [7:0] r;
      logic       last;
   } bgr_beat_type;

   typedef struct packed {
      row_kind_type   kind;
      logic [2:0]     reg_idx;
      logic [31:0]    reg_val;
      pixel_item_type item;
      bit             fixed;
      bit             fixed_has;
      bgr_beat_type   fixed_beat;
   } stim_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_opcode = pfb_pkg::OP_CONVERT;
   logic [31:0] req_pixel_word = '0;
   logic        req_end_of_line = 1'b0;
   logic [7:0]  req_palette_index = '0;
   logic [7:0]  req_palette_red = '0;
   logic [7:0]  req_palette_green = '0;
   logic [7:0]  req_palette_blue = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_blue_out;
   logic [7:0]  rsp_green_out;
   logic [7:0]  rsp_red_out;
   logic        rsp_line_last;

   // Shadow of the block's registers and palette
   logic [2:0]  cfg_bpp = '0;
   logic        cfg_pal = 1'b0;
   logic [31:0] cfg_rmask = '0;
   logic [31:0] cfg_gmask = '0;
   logic [31:0] cfg_bmask = '0;
   logic [23:0] pal_shadow [PAL_DEPTH];

   bgr_beat_type  expected_beats [$];
   stim_row_type  directed_rows [$];
   int            mismatches = 0;
   int            stuck_cycles = 0;
   bit            quiet_run = 1'b0;
   bit            bus_open = 1'b0;

   pixel_format_to_bgr24 u_dut (
      .clock             (clock),
      .reset             (reset),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_pixel_word    (req_pixel_word),
      .req_end_of_line   (req_end_of_line),
      .req_palette_index (req_palette_index),
      .req_palette_red   (req_palette_red),
      .req_palette_green (req_palette_green),
      .req_palette_blue  (req_palette_blue),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_blue_out      (rsp_blue_out),
      .rsp_green_out     (rsp_green_out),
      .rsp_red_out       (rsp_red_out),
      .rsp_line_last     (rsp_line_last)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Scale one masked channel field up to a full byte
   function automatic logic [7:0] scale_channel(logic [31:0] pix, logic [31:0] mask);
      logic [31:0] p;
      logic [31:0] m;
      logic [31:0] f;
      if (mask == '0) return 8'd0;
      p = pix;
      m = mask;
      while (!m[0]) begin
         m = m >> 1;
         p = p >> 1;
      end
      if (m > 32'd255) m = 32'd255;
      f = p & m;
      return 8'((f * 32'd255) / m);
   endfunction

   // Apply one accepted item to the shadow state and work out its beat
   function automatic void convert_pixel(input pixel_item_type it, output bit has,
                                         output bgr_beat_type beat);
      logic [31:0] pix;
      logic [23:0] entry;
      int          nb;
      has  = 1'b0;
      beat = '0;
      if (it.op == pfb_pkg::OP_PAL_WRITE) begin
         pal_shadow[it.pal_idx] = {it.pal_r, it.pal_g, it.pal_b};
         return;
      end
      if (cfg_bpp == 3'd0) return;
      nb  = (int'(cfg_bpp) > WIDEST_PIX) ? WIDEST_PIX : int'(cfg_bpp);
      pix = it.pixel;
      if (nb < 4) pix = pix & ((32'h1 << (nb * 8)) - 32'h1);
      has       = 1'b1;
      beat.last = it.eol;
      if (cfg_pal) begin
         entry  = pal_shadow[pix[7:0]];
         beat.r = entry[23:16];
         beat.g = entry[15:8];
         beat.b = entry[7:0];
      end else begin
         beat.b = scale_channel(pix, cfg_bmask);
         beat.g = scale_channel(pix, cfg_gmask);
         beat.r = scale_channel(pix, cfg_rmask);
      end
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
   endtask

   // Check each result beat against the oldest expectation
   always @(posedge clock) begin : check_beat
      bgr_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("beat with nothing expected: b=%02h g=%02h r=%02h",
                                      rsp_blue_out, rsp_green_out, rsp_red_out));
         end else begin
            want = expected_beats.pop_front();
            if (rsp_blue_out !== want.b)
               report_mismatch($sformatf("blue_out got %02h want %02h", rsp_blue_out, want.b));
            if (rsp_green_out !== want.g)
               report_mismatch($sformatf("green_out got %02h want %02h", rsp_green_out, want.g));
            if (rsp_red_out !== want.r)
               report_mismatch($sformatf("red_out got %02h want %02h", rsp_red_out, want.r));
            if (rsp_line_last !== want.last)
               report_mismatch($sformatf("line_last got %0b want %0b", rsp_line_last, want.last));
         end
      end
   end

   // Stall the result side at random
   always @(negedge clock) begin
      rsp_stall <= !quiet_run && ($urandom_range(0, 99) < 20);
   end

   // Count cycles in which no beat, item or register write moves
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable && pwrite && pready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      wait (stuck_cycles >= STUCK_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   // Drop valid, drain all expected beats, then let the datapath go quiet
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_GAP) @(posedge clock);
   endtask

   // One register write: setup phase, then access phase until pready
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         pfb_pkg::REG_BYTES_PER_PIXEL: cfg_bpp   = val[2:0];
         pfb_pkg::REG_PALETTED_MODE:   cfg_pal   = val[0];
         pfb_pkg::REG_RED_MASK:        cfg_rmask = val;
         pfb_pkg::REG_GREEN_MASK:      cfg_gmask = val;
         pfb_pkg::REG_BLUE_MASK:       cfg_bmask = val;
         default: ;
      endcase
   endtask

   // Offer one item, hold it until accepted, then record its expectation
   task automatic send_item(input stim_row_type row);
      bit           has;
      bgr_beat_type beat;
      @(negedge clock);
      while (!quiet_run && ($urandom_range(0, 99) < 20)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= row.item.op;
      req_pixel_word    <= row.item.pixel;
      req_end_of_line   <= row.item.eol;
      req_palette_index <= row.item.pal_idx;
      req_palette_red   <= row.item.pal_r;
      req_palette_green <= row.item.pal_g;
      req_palette_blue  <= row.item.pal_b;
      do @(posedge clock); while (req_stall);
      convert_pixel(row.item, has, beat);
      if (row.fixed) begin
         has  = row.fixed_has;
         beat = row.fixed_beat;
      end
      if (has) expected_beats.push_back(beat);
   endtask

   task automatic run_row(input stim_row_type row);
      if (row.kind == ROW_CSR) begin
         if (!bus_open) begin
            settle();
            bus_open = 1'b1;
         end
         csr_write(row.reg_idx, row.reg_val);
      end else begin
         if (bus_open) begin
            @(negedge clock);
            psel    <= 1'b0;
            penable <= 1'b0;
            bus_open = 1'b0;
         end
         send_item(row);
      end
   endtask

   function automatic stim_row_type csr_row(logic [2:0] idx, logic [31:0] val);
      stim_row_type row;
      row         = '0;
      row.kind    = ROW_CSR;
      row.reg_idx = idx;
      row.reg_val = val;
      return row;
   endfunction

   function automatic stim_row_type pix_row(logic [31:0] pixel, logic eol);
      stim_row_type row;
      row              = '0;
      row.kind         = ROW_ITEM;
      row.item.op      = pfb_pkg::OP_CONVERT;
      row.item.pixel   = pixel;
      row.item.eol     = eol;
      row.item.pal_idx = 8'($urandom);
      row.item.pal_r   = 8'($urandom);
      row.item.pal_g   = 8'($urandom);
      row.item.pal_b   = 8'($urandom);
      return row;
   endfunction

   function automatic stim_row_type pal_row(logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                                            logic [7:0] b);
      stim_row_type row;
      row              = '0;
      row.kind         = ROW_ITEM;
      row.item.op      = pfb_pkg::OP_PAL_WRITE;
      row.item.pixel   = $urandom;
      row.item.eol     = 1'($urandom);
      row.item.pal_idx = idx;
      row.item.pal_r   = r;
      row.item.pal_g   = g;
      row.item.pal_b   = b;
      return row;
   endfunction

   // Pin the expected outcome of a row instead of predicting it
   function automatic stim_row_type fixed_beat(stim_row_type row, bit has, logic [7:0] b,
                                               logic [7:0] g, logic [7:0] r);
      row.fixed           = 1'b1;
      row.fixed_has       = has;
      row.fixed_beat.b    = b;
      row.fixed_beat.g    = g;
      row.fixed_beat.r    = r;
      row.fixed_beat.last = row.item.eol;
      return row;
   endfunction

   function automatic logic [31:0] rand_mask();
      int w;
      int s;
      case ($urandom_range(0, 4))
         0: return 32'h0;
         1: return 32'hffff_ffff;
         2: begin
            w = $urandom_range(1, 12);
            s = $urandom_range(0, 31);
            return ((32'h1 << w) - 32'h1) << s;
         end
         3: return $urandom;
         default: return 32'h1 << $urandom_range(0, 31);
      endcase
   endfunction

   function automatic stim_row_type rand_item_row();
      stim_row_type row;
      if ($urandom_range(0, 99) < 25) begin
         row = pal_row(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
         row = pix_row($urandom, 1'($urandom));
      end
      return row;
   endfunction

   initial begin
      int pick;
      logic [2:0] bpp;

      foreach (pal_shadow[i]) pal_shadow[i] = '0;

      // Directed rows: reset state, palette lookups, masks at their extremes
      directed_rows.push_back(fixed_beat(pix_row(32'hffff_ffff, 1'b1), 0, 0, 0, 0));
      directed_rows.push_back(fixed_beat(pal_row(8'h00, 8'h11, 8'h22, 8'h33), 0, 0, 0, 0));
      directed_rows.push_back(fixed_beat(pal_row(8'hff, 8'hff, 8'hff, 8'hff), 0, 0, 0, 0));
      directed_rows.push_back(csr_row(pfb_pkg::REG_BYTES_PER_PIXEL, 32'd1));
      directed_rows.push_back(csr_row(pfb_pkg::REG_PALETTED_MODE, 32'd1));
      directed_rows.push_back(fixed_beat(pix_row(32'h0000_0000, 1'b1), 1, 8'h33, 8'h22, 8'h11));
      directed_rows.push_back(fixed_beat(pix_row(32'hffff_ffff, 1'b0), 1, 8'hff, 8'hff, 8'hff));
      // never-written entry reads as zero
      directed_rows.push_back(fixed_beat(pix_row(32'h1234_5601, 1'b0), 1, 0, 0, 0));
      // oversized pixel size saturates to four bytes
      directed_rows.push_back(csr_row(pfb_pkg::REG_BYTES_PER_PIXEL, 32'd7));
      directed_rows.push_back(fixed_beat(pix_row(32'habcd_ef00, 1'b1), 1, 8'h33, 8'h22, 8'h11));
      directed_rows.push_back(csr_row(pfb_pkg::REG_PALETTED_MODE, 32'd0));
      directed_rows.push_back(csr_row(pfb_pkg::REG_RED_MASK, 32'h00ff_0000));
      directed_rows.push_back(csr_row(pfb_pkg::REG_GREEN_MASK, 32'h0000_ff00));
      directed_rows.push_back(csr_row(pfb_pkg::REG_BLUE_MASK, 32'h0000_00ff));
      directed_rows.push_back(csr_row(pfb_pkg::REG_BYTES_PER_PIXEL, 32'd4));
      // palette write still lands while in RGB mode
      directed_rows.push_back(fixed_beat(pal_row(8'h07, 8'h01, 8'h02, 8'h03), 0, 0, 0, 0));
      directed_rows.push_back(fixed_beat(pix_row(32'h0000_0000, 1'b0), 1, 0, 0, 0));
      directed_rows.push_back(fixed_beat(pix_row(32'hffff_ffff, 1'b1), 1, 8'hff, 8'hff, 8'hff));
      directed_rows.push_back(pix_row(32'h0012_3456, 1'b0));
      directed_rows.push_back(csr_row(pfb_pkg::REG_RED_MASK, 32'h0000_f800));
      directed_rows.push_back(csr_row(pfb_pkg::REG_GREEN_MASK, 32'h0000_07e0));
      directed_rows.push_back(csr_row(pfb_pkg::REG_BLUE_MASK, 32'h0000_001f));
      directed_rows.push_back(csr_row(pfb_pkg::REG_BYTES_PER_PIXEL, 32'd2));
      directed_rows.push_back(fixed_beat(pix_row(32'h0000_ffff, 1'b1), 1, 8'hff, 8'hff, 8'hff));
      directed_rows.push_back(pix_row(32'h1234_abcd, 1'b0));
      // zero red mask, full green mask, blue field above the pixel width
      directed_rows.push_back(csr_row(pfb_pkg::REG_RED_MASK, 32'h0));
      directed_rows.push_back(csr_row(pfb_pkg::REG_GREEN_MASK, 32'hffff_ffff));
      directed_rows.push_back(csr_row(pfb_pkg::REG_BLUE_MASK, 32'h8000_0000));
      directed_rows.push_back(csr_row(pfb_pkg::REG_BYTES_PER_PIXEL, 32'd3));
      directed_rows.push_back(fixed_beat(pix_row(32'hffff_ffff, 1'b0), 1, 8'h00, 8'hff, 8'h00));
      directed_rows.push_back(pix_row(32'h00a5_a5a5, 1'b1));
      directed_rows.push_back(csr_row(pfb_pkg::REG_RED_MASK, 32'h0000_0001));
      directed_rows.push_back(csr_row(pfb_pkg::REG_GREEN_MASK, 32'h0000_0006));
      directed_rows.push_back(csr_row(pfb_pkg::REG_BLUE_MASK, 32'h0000_0700));
      directed_rows.push_back(csr_row(pfb_pkg::REG_BYTES_PER_PIXEL, 32'd4));
      directed_rows.push_back(pix_row(32'h0000_0703, 1'b0));
      directed_rows.push_back(pix_row(32'h0000_0005, 1'b1));
      directed_rows.push_back(pix_row(32'hffff_ffff, 1'b0));
      // invalid format drops converts but still takes palette writes
      directed_rows.push_back(csr_row(pfb_pkg::REG_BYTES_PER_PIXEL, 32'd0));
      directed_rows.push_back(fixed_beat(pix_row(32'hffff_ffff, 1'b1), 0, 0, 0, 0));
      directed_rows.push_back(fixed_beat(pal_row(8'h80, 8'haa, 8'hbb, 8'hcc), 0, 0, 0, 0));
      directed_rows.push_back(csr_row(pfb_pkg::REG_PALETTED_MODE, 32'd1));
      directed_rows.push_back(csr_row(pfb_pkg::REG_BYTES_PER_PIXEL, 32'd3));
      directed_rows.push_back(fixed_beat(pix_row(32'h0000_0080, 1'b1), 1, 8'hcc, 8'hbb, 8'haa));

      // Hold reset, then release it
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) run_row(directed_rows[i]);

      // Random phases, each with a fresh register setting
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         pick = $urandom_range(0, 11);
         if (pick == 0) bpp = 3'd0;
         else if (pick == 1) bpp = 3'($urandom_range(5, 7));
         else bpp = 3'((pick % 4) + 1);
         run_row(csr_row(pfb_pkg::REG_BYTES_PER_PIXEL, {29'd0, bpp}));
         run_row(csr_row(pfb_pkg::REG_PALETTED_MODE, 32'($urandom_range(0, 1))));
         run_row(csr_row(pfb_pkg::REG_RED_MASK, rand_mask()));
         run_row(csr_row(pfb_pkg::REG_GREEN_MASK, rand_mask()));
         run_row(csr_row(pfb_pkg::REG_BLUE_MASK, rand_mask()));
         // one phase runs flat out on both sides
         quiet_run = (ph == 4);
         for (int n = 0; n < PHASE_ITEMS; n++) run_row(rand_item_row());
      end
      quiet_run = 1'b0;

      settle();
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/pfb_pkg.sv
hdl/pfb_csr.sv
hdl/pfb_datapath.sv
hdl/pfb_ctrl.sv
hdl/pixel_format_to_bgr24.sv
tb/tb.sv
